// ===== hw/rtl/ffba_pkg.sv =====
package ffba_pkg;

    localparam int DEF_NUM_LINES = 1024;

    localparam int CAP_W    = 11;
    localparam int LEN_W    = 11;
    localparam int BASE_W   = 10;
    localparam int STATUS_W = 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_NO_SPACE      = 2'd1,
        ST_OUT_OF_BOUNDS = 2'd2
    } status_t;

endpackage

// ===== hw/rtl/ffba_if.sv =====
interface ffba_req_if
    import ffba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [LEN_W-1:0]  run_length;
    logic [BASE_W-1:0] free_base;

    modport source (output valid, req_type, run_length, free_base, input ready);
    modport sink   (input valid, req_type, run_length, free_base, output ready);
endinterface

interface ffba_rsp_if
    import ffba_pkg::*;
();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [BASE_W-1:0] alloc_base;

    modport source (output valid, status, alloc_base, input ready);
    modport sink   (input valid, status, alloc_base, output ready);
endinterface

// ===== hw/rtl/ffba_ram.sv =====
module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/first_fit_bitmap_allocator.sv =====
// Channel   Dir  Transfer when          Payload
// req       in   req.valid & ready     req_type, run_length, free_base
// rsp       out  rsp.valid & ready     status, alloc_base
// apb cfg   in   psel&penable&pwrite   capacity_lines at byte address 0
//
// Bitmap is kept as 32-line words in a RAM; one evaluation unit walks it a word per cycle.
// Allocate: accept in IDLE, scan up to ceil(capacity/32) words (SCAN), set the bits of the run
//   word by word (MARK), then load the result (DONE). Free: accept, clear words (MARK), DONE.
// Zero-length, oversize and out-of-bounds requests go from the accept straight to DONE.
// After reset a clearing pass zeroes all ceil(min(NUM_LINES,2047)/32) words; no req is taken.
// The result waits in an output register; the next request is taken meanwhile, and a
//   finished request holds the sequencer until that register is free.
module first_fit_bitmap_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_LINES = DEF_NUM_LINES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ffba_req_if.sink    req,
    ffba_rsp_if.source  rsp
);

    localparam int WORD_W     = 32;
    localparam int OFS_W      = $clog2(WORD_W);
    localparam int WIDX_W     = CAP_W - OFS_W;
    localparam int CAP_MAX    = (1 << CAP_W) - 1;
    localparam int USED_LINES = (NUM_LINES < CAP_MAX) ? NUM_LINES : CAP_MAX;
    localparam int DEPTH      = (USED_LINES + WORD_W - 1) / WORD_W;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_W     = 3;

    localparam logic [CAP_W-1:0] USED_CAP  = CAP_W'(USED_LINES);
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic             REG_CAPACITY = 1'b0;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // count of free lines from bit 0 upward
    function automatic logic [OFS_W:0] head_ones(logic [WORD_W-1:0] v);
        logic [OFS_W:0] n;
        n = (OFS_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                n = (OFS_W+1)'(i);
            end
        end
        return n;
    endfunction

    // count of free lines from the top bit downward
    function automatic logic [OFS_W:0] tail_ones(logic [WORD_W-1:0] v);
        logic [OFS_W:0] n;
        n = (OFS_W+1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (!v[i])
            begin
                n = (OFS_W+1)'(WORD_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [OFS_W-1:0] lowest_one(logic [WORD_W-1:0] v);
        logic [OFS_W-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = OFS_W'(i);
            end
        end
        return p;
    endfunction

    // bit i set where lines i .. i+l-1 of the word are all free; windows are
    // built by prepending power-of-two blocks, so every shift is a constant
    function automatic logic [WORD_W-1:0] fit_windows(logic [WORD_W-1:0] f,
                                                      logic [OFS_W-1:0] l);
        logic [2*WORD_W-1:0] g;
        logic [2*WORD_W-1:0] acc;
        g   = {{WORD_W{1'b0}}, f};
        acc = '1;
        for (int k = 0; k < OFS_W; k++)
        begin
            if (l[k])
            begin
                acc = g & (acc >> (1 << k));
            end
            g = g & (g >> (1 << k));
        end
        return acc[WORD_W-1:0];
    endfunction

    // lines of word w that lie below line lim
    function automatic logic [WORD_W-1:0] below_mask(logic [WIDX_W-1:0] w,
                                                     logic [CAP_W-1:0] lim);
        logic [WIDX_W-1:0] lim_w;
        logic [WORD_W-1:0] m;
        lim_w = lim[CAP_W-1:OFS_W];
        if (w < lim_w)
        begin
            m = '1;
        end
        else if (w == lim_w)
        begin
            m = ~({WORD_W{1'b1}} << lim[OFS_W-1:0]);
        end
        else
        begin
            m = '0;
        end
        return m;
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    logic              op_set_reg, op_set_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CAP_W-1:0]  run_reg, run_next;
    logic [CAP_W-1:0]  start_reg, start_next;
    logic [CAP_W-1:0]  lo_reg, lo_next;
    logic [CAP_W-1:0]  hi_reg, hi_next;
    logic [WIDX_W-1:0] word_reg, word_next;
    status_t           res_status_reg, res_status_next;
    logic [BASE_W-1:0] res_base_reg, res_base_next;
    status_t           out_status_reg, out_status_next;
    logic [BASE_W-1:0] out_base_reg, out_base_next;

    logic              req_fire, rsp_fire, out_load, cfg_write;
    logic [CAP_W-1:0]  cap_eff, cap_m1, hi_m1, word_base, hit_start;
    logic [WIDX_W-1:0] scan_last_word, mark_last_word, rd_word;
    logic [CAP_W:0]    reach, free_end;
    logic [OFS_W:0]    head_free, tail_free;
    logic [OFS_W-1:0]  fit_pos;
    logic [WORD_W-1:0] free_bits, fit_bits, range_bits;
    logic              cross_hit, inside_hit;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    ffba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_word[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign prdata    = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? 32'(cap_reg) : '0;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.alloc_base = out_base_reg;
    assign rsp_fire   = rsp.valid && rsp.ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign cap_eff  = (cap_reg > USED_CAP) ? USED_CAP : cap_reg;
    assign cap_m1   = cap_eff - 1'b1;
    assign hi_m1    = hi_reg - 1'b1;
    assign scan_last_word = cap_m1[CAP_W-1:OFS_W];
    assign mark_last_word = hi_m1[CAP_W-1:OFS_W];
    assign free_end = (CAP_W+1)'(req.free_base) + (CAP_W+1)'(req.run_length);

    // word evaluation unit; lines at or above capacity count as occupied
    assign word_base  = {word_reg, {OFS_W{1'b0}}};
    assign free_bits  = ~ram_rdata & below_mask(word_reg, cap_eff);
    assign head_free  = head_ones(free_bits);
    assign tail_free  = tail_ones(free_bits);
    assign fit_bits   = fit_windows(free_bits, len_reg[OFS_W-1:0]);
    assign fit_pos    = lowest_one(fit_bits);
    assign reach      = {1'b0, run_reg} + (CAP_W+1)'(head_free);
    assign cross_hit  = reach >= (CAP_W+1)'(len_reg);
    assign inside_hit = (len_reg < LEN_W'(WORD_W)) && (|fit_bits);
    assign hit_start  = cross_hit ? ((run_reg == '0) ? word_base : start_reg)
                                  : word_base + CAP_W'(fit_pos);

    assign range_bits = below_mask(word_reg, hi_reg) & ~below_mask(word_reg, lo_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_set_next     = op_set_reg;
        len_next        = len_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        word_next       = word_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        rd_word         = word_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg[AW-1:0];
        ram_wdata       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                // prefetch the first word the request will touch
                rd_word = (req.req_type == REQ_FREE)
                          ? WIDX_W'(req.free_base[BASE_W-1:OFS_W]) : '0;
                if (req_fire)
                begin
                    len_next      = req.run_length;
                    op_set_next   = (req.req_type == REQ_ALLOC);
                    res_base_next = '0;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if ((req.run_length == '0) || (req.run_length > cap_eff))
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            run_next   = '0;
                            start_next = '0;
                            word_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_end > {1'b0, cap_eff})
                        begin
                            res_status_next = ST_OUT_OF_BOUNDS;
                            state_next      = S_DONE;
                        end
                        else if (req.run_length == '0)
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            lo_next         = CAP_W'(req.free_base);
                            hi_next         = free_end[CAP_W-1:0];
                            word_next       = WIDX_W'(req.free_base[BASE_W-1:OFS_W]);
                            res_status_next = ST_OK;
                            state_next      = S_MARK;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (cross_hit || inside_hit)
                begin
                    lo_next         = hit_start;
                    hi_next         = hit_start + len_reg;
                    word_next       = hit_start[CAP_W-1:OFS_W];
                    rd_word         = hit_start[CAP_W-1:OFS_W];
                    res_status_next = ST_OK;
                    res_base_next   = hit_start[BASE_W-1:0];
                    state_next      = S_MARK;
                end
                else if (word_reg == scan_last_word)
                begin
                    res_status_next = ST_NO_SPACE;
                    res_base_next   = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                    rd_word   = word_reg + 1'b1;
                    if (&free_bits)
                    begin
                        run_next = run_reg + CAP_W'(WORD_W);
                        if (run_reg == '0)
                        begin
                            start_next = word_base;
                        end
                    end
                    else
                    begin
                        // run carried out of this word starts after its top occupied line
                        run_next   = CAP_W'(tail_free);
                        start_next = word_base + CAP_W'(WORD_W) - CAP_W'(tail_free);
                    end
                end
            end

            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = op_set_reg ? (ram_rdata | range_bits)
                                       : (ram_rdata & ~range_bits);
                if (word_reg == mark_last_word)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                    rd_word   = word_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_base_next   = out_base_reg;
        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_base_next   = res_base_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_set_reg     <= op_set_next;
        len_reg        <= len_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        out_status_reg <= out_status_next;
        out_base_reg   <= out_base_next;
    end

    a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) || (state_reg == S_DONE)) |-> !ram_we)
        else $error("bitmap written outside clear or mark");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after a request transfer");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished request");

endmodule

// ===== test/testbench.sv =====
module testbench
    import ffba_pkg::*;
();

    localparam int NUM_LINES = DEF_NUM_LINES;

    localparam logic [2:0] CAPACITY_ADDR = 3'd0;

    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 4000;

    typedef struct {
        logic              req_type;
        logic [LEN_W-1:0]  run_length;
        logic [BASE_W-1:0] free_base;
        bit                drain_first;
    } alloc_req_t;

    typedef struct {
        status_t           status;
        logic [BASE_W-1:0] alloc_base;
    } alloc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_bitmap_allocator #(
        .NUM_LINES (NUM_LINES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // predictor state
    bit         line_busy [NUM_LINES];
    int         capacity_setting = 1024;

    alloc_req_t request_queue [$];
    alloc_rsp_t expected_results [$];
    alloc_req_t offered;
    bit         req_busy;
    int         send_gap;

    alloc_rsp_t wanted;
    int         results_seen;
    int         hold_left;
    int         recv_stall;
    bit         hold_done;
    logic       rsp_held;

    int         mismatch_count;
    int         stuck_cycles;
    int         cycle_count;
    logic       idle_window;
    logic       tail_quiet;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic alloc_rsp_t predict_result(alloc_req_t r);
        alloc_rsp_t res;
        int         cap;
        int         len;
        int         base;
        int         run;
        int         start;
        bit         found;
        res.status     = ST_OK;
        res.alloc_base = '0;
        cap   = capacity_setting > NUM_LINES ? NUM_LINES : capacity_setting;
        len   = r.run_length;
        base  = r.free_base;
        run   = 0;
        start = 0;
        found = 1'b0;
        if (r.req_type == REQ_ALLOC)
        begin
            if (len != 0 && len <= cap)
            begin
                for (int i = 0; i < cap && !found; i++)
                begin
                    if (line_busy[i])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                            start = i;
                        run++;
                        found = (run == len);
                    end
                end
            end
            if (found)
            begin
                for (int k = 0; k < len; k++)
                    line_busy[start + k] = 1'b1;
                res.alloc_base = BASE_W'(start);
            end
            else
            begin
                res.status = ST_NO_SPACE;
            end
        end
        else if (base + len > cap)
        begin
            res.status = ST_OUT_OF_BOUNDS;
        end
        else
        begin
            // no ownership check: lines are cleared whether taken or not
            for (int k = 0; k < len; k++)
                line_busy[base + k] = 1'b0;
        end
        return res;
    endfunction

    function automatic void add_req(logic kind, int len, int base);
        alloc_req_t r;
        r.req_type    = kind;
        r.run_length  = LEN_W'(len);
        r.free_base   = BASE_W'(base);
        r.drain_first = 1'b0;
        request_queue.push_back(r);
    endfunction

    function automatic alloc_req_t random_request(int cap);
        alloc_req_t r;
        int         pick;
        int         len;
        int         top;
        int         base;
        r.req_type    = REQ_ALLOC;
        r.free_base   = BASE_W'($urandom_range(0, 1023));
        r.drain_first = ($urandom_range(0, 39) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 90)
                len = $urandom_range(9, 64);
            else if (pick < 96)
                len = $urandom_range(1, cap > 1 ? cap : 1);
            else
                len = $urandom_range(0, 2047);
            r.run_length = LEN_W'(len);
        end
        else if (pick < 90)
        begin
            // free inside the managed range
            r.req_type   = REQ_FREE;
            len          = $urandom_range(0, cap < 48 ? cap : 48);
            top          = cap - len > 1023 ? 1023 : cap - len;
            r.run_length = LEN_W'(len);
            r.free_base  = BASE_W'($urandom_range(0, top));
        end
        else if (pick < 97)
        begin
            // free reaching past the capacity
            r.req_type   = REQ_FREE;
            base         = $urandom_range(0, 1023);
            len          = $urandom_range(cap > base ? cap - base + 1 : 1, 2047);
            r.run_length = LEN_W'(len);
            r.free_base  = BASE_W'(base);
        end
        else
        begin
            r.req_type   = 1'($urandom_range(0, 1));
            r.run_length = LEN_W'($urandom_range(0, 2047));
        end
        return r;
    endfunction

    task automatic queue_random(int count);
        int cap;
        cap = capacity_setting > NUM_LINES ? NUM_LINES : capacity_setting;
        repeat (count)
            request_queue.push_back(random_request(cap));
    endtask

    task automatic report_mismatch(string what);
        if (mismatch_count < 100)
            $display("%0t: result %0d: %s", $time, results_seen, what);
        mismatch_count++;
    endtask

    task automatic wait_for_idle();
        while (request_queue.size() != 0 || req_busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_setting = value & 'h7ff;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(predict_result(offered));
                req_busy = 1'b0;
            end
            if (!req_busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() == 0 ||
                         (!tail_quiet && request_queue[0].drain_first &&
                          expected_results.size() != 0))
                begin
                    req_ch.valid <= 1'b0;
                end
                else if (idle_window && !tail_quiet && !rsp_held &&
                         $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 15);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    offered  = request_queue.pop_front();
                    req_busy = 1'b1;
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= offered.req_type;
                    req_ch.run_length <= offered.run_length;
                    req_ch.free_base  <= offered.free_base;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_held     <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer status=%0d base=%0d",
                                              rsp_ch.status, rsp_ch.alloc_base));
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (rsp_ch.status !== wanted.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, wanted.status));
                    if (rsp_ch.alloc_base !== wanted.alloc_base)
                        report_mismatch($sformatf("alloc_base %0d, expected %0d",
                                                  rsp_ch.alloc_base, wanted.alloc_base));
                end
                results_seen++;
            end
            // one long hold-off so the output register and the request side back up
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_window && !tail_quiet && $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
            rsp_held <= (hold_left > 0);
        end
    end

    // idle windows and stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycle_count  <= 0;
            idle_window  <= 1'b0;
            stuck_cycles <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 256 == 0)
                idle_window <= ($urandom_range(0, 2) != 0);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (psel && penable && pwrite && pready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("first_fit_bitmap_allocator: mismatch");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ALLOC;
        req_ch.run_length = '0;
        req_ch.free_base  = '0;
        rsp_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = CAPACITY_ADDR;
        pwdata            = '0;
        tail_quiet        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // full capacity after reset
        add_req(REQ_ALLOC, 0, 0);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_ALLOC, 1024, 0);
        add_req(REQ_ALLOC, 2047, 0);
        add_req(REQ_FREE, 1, 0);
        add_req(REQ_ALLOC, 1024, 0);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_FREE, 1, 1023);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_FREE, 2, 1023);
        add_req(REQ_FREE, 2047, 1023);
        add_req(REQ_FREE, 1024, 0);
        add_req(REQ_FREE, 10, 500);
        add_req(REQ_FREE, 0, 1023);
        add_req(REQ_ALLOC, 16, 0);
        add_req(REQ_ALLOC, 16, 0);
        add_req(REQ_FREE, 12, 0);
        add_req(REQ_ALLOC, 13, 0);
        add_req(REQ_ALLOC, 12, 0);
        add_req(REQ_ALLOC, 1, 1023);
        add_req(REQ_FREE, 1024, 0);
        queue_random(100);
        wait_for_idle();

        // nothing managed
        write_capacity(0);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_ALLOC, 0, 0);
        add_req(REQ_FREE, 0, 0);
        add_req(REQ_FREE, 0, 3);
        add_req(REQ_FREE, 1, 0);
        queue_random(20);
        wait_for_idle();

        write_capacity(1);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_ALLOC, 1, 0);
        add_req(REQ_ALLOC, 2, 0);
        add_req(REQ_FREE, 2, 0);
        add_req(REQ_FREE, 1, 0);
        add_req(REQ_ALLOC, 1, 0);
        queue_random(30);
        wait_for_idle();

        // above the line count: clamped to the full bitmap
        write_capacity(2047);
        add_req(REQ_ALLOC, 1024, 0);
        add_req(REQ_FREE, 1024, 0);
        add_req(REQ_ALLOC, 1024, 0);
        add_req(REQ_FREE, 1024, 0);
        queue_random(350);
        wait_for_idle();

        // lowered: upper lines keep their bits until the capacity comes back
        write_capacity(100);
        queue_random(100);
        wait_for_idle();

        write_capacity(1024);
        queue_random(100);
        wait_for_idle();

        write_capacity($urandom_range(2, 1024));
        @(posedge clk);
        tail_quiet <= 1'b1;
        queue_random(150);
        wait_for_idle();

        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("first_fit_bitmap_allocator: match");
        else
            $display("first_fit_bitmap_allocator: mismatch");
        $finish;
    end

endmodule

// ===== first_fit_bitmap_allocator.f =====
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_if.sv
hw/rtl/ffba_ram.sv
hw/rtl/first_fit_bitmap_allocator.sv
test/testbench.sv
